@@ design/checked_int32_alu_defines.svh @@
// assertion macros for the checked alu
`ifndef CHECKED_INT32_ALU_DEFINES_SVH
`define CHECKED_INT32_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CIA_ASSERT_IMP(label, ante, cons)
`define CIA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/cia_pkg.sv @@
// shared types and constants for the checked alu
`timescale 1ns / 1ps
package cia_pkg;
  localparam int W = 32;
  localparam int NCELL = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_REM = 3'd4, OP_INC = 3'd5, OP_DEC = 3'd6, OP_NOP = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2, ST_RSV = 2'd3
  } status_t;

  // word travelling down the cell chain
  typedef struct packed {
    logic           vld;
    op_t            op;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   quick;    // result of add/sub/inc/dec, or a
    status_t        qstat;    // status of quick path
    logic [2*W-1:0] prod;     // signed product
    logic           neg_q;    // quotient sign
    logic           neg_r;    // remainder sign
    logic [W-1:0]   dvsr;     // divisor magnitude
    logic [W:0]     rem;      // partial remainder
    logic [W-1:0]   quo;      // dividend shifting out, quotient shifting in
    logic           eq;
    logic           lt;
    logic           gt;
  } slot_t;
endpackage

@@ design/checked_int32_alu.sv @@
// top level: checked 32-bit alu as a chain of division cells
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, op, a, b              | in
//  out     | out_valid, out_stall, result, status, cmp | out
// one word per cycle while out_stall is low; stages: entry, 32 divide cells, output
// the 32-cell division chain sets the latency; every op rides the chain
// rst is synchronous and clears all valid bits
// out_stall freezes the whole chain; in_stall = out_stall
`timescale 1ns / 1ps
`include "checked_int32_alu_defines.svh"
module checked_int32_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic [1:0]  status,
  output logic        equal,
  output logic        less,
  output logic        greater
);
  logic adv;
  cia_pkg::slot_t chain [cia_pkg::NCELL+1];
  logic v0;

  assign adv = !out_stall;
  assign in_stall = out_stall;

  // entry valid
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
  end

  cia_front u_front (.clk(clk), .adv(adv), .in_fire(in_valid), .op(op), .a(a), .b(b),
                     .slot(chain[0]));

  // row of divide cells
  for (genvar i = 0; i < cia_pkg::NCELL; i++) begin : g_cell
    cia_pkg::slot_t din;
    always_comb begin
      din = chain[i];
      if (i == 0) din.vld = v0;
    end
    cia_cell u_cell (.clk(clk), .rst(rst), .adv(adv), .din(din), .dout(chain[i+1]));
  end

  cia_back u_back (.clk(clk), .rst(rst), .adv(adv), .din(chain[cia_pkg::NCELL]),
                   .ovld(out_valid), .result(result), .status(status),
                   .equal(equal), .less(less), .greater(greater));

  `CIA_ASSERT_IMP(a_flags_excl, out_valid, !(less && greater) && !(equal && (less || greater)))
  `CIA_ASSERT_IMP(a_status_code, out_valid, status != cia_pkg::ST_RSV)
  `CIA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result))
endmodule

@@ design/cia_front.sv @@
// entry stage: fast ops, compare, product, divider setup
`timescale 1ns / 1ps
module cia_front (
  input  logic                clk,
  input  logic                adv,
  input  logic                in_fire,
  input  logic [2:0]          op,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output cia_pkg::slot_t      slot
);
  cia_pkg::slot_t s;
  logic signed [32:0] sum;
  logic [31:0] amag;
  logic signed [63:0] p;

  // combinational setup of the entering word
  always_comb begin
    s = '0;
    s.vld = in_fire;
    s.op = cia_pkg::op_t'(op);
    s.a = a;
    s.b = b;
    s.prod = p;
    s.eq = (a == b);
    s.lt = ($signed(a) < $signed(b));
    s.gt = ($signed(a) > $signed(b));
    sum = 33'sd0;
    unique case (cia_pkg::op_t'(op))
      cia_pkg::OP_ADD: sum = $signed({a[31], a}) + $signed({b[31], b});
      cia_pkg::OP_SUB: sum = $signed({a[31], a}) - $signed({b[31], b});
      cia_pkg::OP_INC: sum = $signed({a[31], a}) + 33'sd1;
      cia_pkg::OP_DEC: sum = $signed({a[31], a}) - 33'sd1;
      default: sum = $signed({a[31], a});
    endcase
    s.quick = a;
    s.qstat = cia_pkg::ST_OK;
    if (sum[32] != sum[31]) s.qstat = cia_pkg::ST_OVF;
    else s.quick = sum[31:0];
    if ((cia_pkg::op_t'(op) == cia_pkg::OP_DIV || cia_pkg::op_t'(op) == cia_pkg::OP_REM)
        && b == '0) begin
      s.qstat = cia_pkg::ST_DIV0;
      s.quick = a;
    end
    s.neg_q = a[31] ^ b[31];
    s.neg_r = a[31];
    amag = a[31] ? (~a + 32'd1) : a;
    s.dvsr = b[31] ? (~b + 32'd1) : b;
    s.quo = amag;
    s.rem = '0;
  end

  // one 32x32 multiply, registered
  assign p = $signed(a) * $signed(b);

  // entry register
  always_ff @(posedge clk) begin
    if (adv) begin
      slot <= s;
    end
  end
endmodule

@@ design/cia_cell.sv @@
// one restoring division step cell
`timescale 1ns / 1ps
module cia_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  cia_pkg::slot_t din,
  output cia_pkg::slot_t dout
);
  cia_pkg::slot_t nxt;
  logic [32:0] sh;
  logic [32:0] dif;

  // shift in next dividend bit, trial subtract
  always_comb begin
    nxt = din;
    sh = {din.rem[31:0], din.quo[31]};
    dif = sh - {1'b0, din.dvsr};
    if (!dif[32]) begin
      nxt.rem = dif;
      nxt.quo = {din.quo[30:0], 1'b1};
    end else begin
      nxt.rem = sh;
      nxt.quo = {din.quo[30:0], 1'b0};
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) dout.vld <= 1'b0;
    else if (adv) dout.vld <= din.vld;
    if (adv) begin
      dout.op <= nxt.op; dout.a <= nxt.a; dout.b <= nxt.b;
      dout.quick <= nxt.quick; dout.qstat <= nxt.qstat; dout.prod <= nxt.prod;
      dout.neg_q <= nxt.neg_q; dout.neg_r <= nxt.neg_r; dout.dvsr <= nxt.dvsr;
      dout.rem <= nxt.rem; dout.quo <= nxt.quo;
      dout.eq <= nxt.eq; dout.lt <= nxt.lt; dout.gt <= nxt.gt;
    end
  end
endmodule

@@ design/cia_back.sv @@
// final stage: pick the result and check range
`timescale 1ns / 1ps
module cia_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  cia_pkg::slot_t din,
  output logic           ovld,
  output logic [31:0]    result,
  output logic [1:0]     status,
  output logic           equal,
  output logic           less,
  output logic           greater
);
  logic [31:0] r;
  cia_pkg::status_t st;
  logic [31:0] q, rm;

  // sign fixup and selection
  always_comb begin
    q = din.neg_q ? (~din.quo + 32'd1) : din.quo;
    rm = din.neg_r ? (~din.rem[31:0] + 32'd1) : din.rem[31:0];
    r = din.quick;
    st = din.qstat;
    unique case (din.op)
      cia_pkg::OP_MUL: begin
        if (din.prod[63:31] != {33{din.prod[31]}}) st = cia_pkg::ST_OVF;
        else r = din.prod[31:0];
      end
      cia_pkg::OP_DIV: begin
        if (st == cia_pkg::ST_OK) begin
          // only int_min by -1 leaves the range
          if (!din.neg_q && din.quo[31]) st = cia_pkg::ST_OVF;
          else r = q;
        end
      end
      cia_pkg::OP_REM: if (st == cia_pkg::ST_OK) r = rm;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (adv) ovld <= din.vld;
    if (adv) begin
      result <= r;
      status <= st;
      equal <= din.eq;
      less <= din.lt;
      greater <= din.gt;
    end
  end
endmodule
